// ===== hdl/bfha_pkg.sv =====
// Shared constants and types for the best-fit heap allocator.
// Depends on nothing; every module of the allocator imports it.
package bfha_pkg;

   // Heap geometry in bytes and words.
   localparam int HEAP_BYTES = 4096;
   localparam int WORDS      = HEAP_BYTES / 4;
   localparam int IDX_W      = $clog2(WORDS);
   // Byte positions carry one spare bit so that a sum of position and size cannot wrap.
   localparam int POS_W      = $clog2(HEAP_BYTES) + 1;

   localparam logic [POS_W-1:0] END_POS    = POS_W'(HEAP_BYTES - 4);
   localparam logic [POS_W-1:0] FIRST_POS  = POS_W'(4);
   localparam logic [POS_W-1:0] FIRST_SIZE = POS_W'(HEAP_BYTES - 8);
   localparam logic [31:0]      LIST_TERM  = 32'd1;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_SIZE = 3'd1,
      ST_NO_FIT   = 3'd2,
      ST_BAD_PTR  = 3'd3,
      ST_DBL_FREE = 3'd4
   } status_type;

endpackage

// ===== hdl/best_fit_heap_allocator_top.sv =====
// Best-fit heap allocator: heap memory, block list walker and split/merge sequencer.
// Depends on bfha_pkg.
//
//   Channel | Direction | Ports                                     | Handshake
//   req     | in        | req_mode, req_req_bytes, req_block_addr   | req_valid / req_ready
//   rsp     | out       | rsp_payload_addr, rsp_status              | rsp_valid / rsp_ready
//
// One request at a time. A request is taken in S_IDLE; the list walk reads each block header
// (S_WRD) and checks it (S_WCHK); the split, merge and write-back steps then go through the
// single memory port, and S_DONE hands the result over.
// Requests with a zero size or a null or misaligned pointer go from S_IDLE straight to S_DONE.
// After reset a clearing pass over all 1024 words writes the initial heap image; no transfer
// on req is taken meanwhile. A result held on rsp stalls the sequencer at its last step.
module best_fit_heap_allocator_top
   import bfha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [11:0] req_req_bytes,
   input  logic [11:0] req_block_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_payload_addr,
   output logic [2:0]  rsp_status
);

   typedef enum logic [13:0] {
      S_CLEAR = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_WRD   = 14'b00000000000100,
      S_WCHK  = 14'b00000000001000,
      S_ARB   = 14'b00000000010000,
      S_ASPL  = 14'b00000000100000,
      S_AW2   = 14'b00000001000000,
      S_ANX   = 14'b00000010000000,
      S_AHDR  = 14'b00000100000000,
      S_FNX   = 14'b00001000000000,
      S_FRP   = 14'b00010000000000,
      S_FP    = 14'b00100000000000,
      S_FW2   = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic             free_ff, free_in;
   logic             found_ff, found_in;
   logic             bpa_ff, bpa_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] best_ff, best_in;
   logic [POS_W-1:0] bsz_ff, bsz_in;
   logic [POS_W-1:0] need_ff, need_in;
   logic [POS_W-1:0] hb_ff, hb_in;
   logic [POS_W-1:0] prev_ff, prev_in;
   logic [POS_W-1:0] base_ff, base_in;
   logic [POS_W-1:0] tot_ff, tot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [11:0]      rsp_addr_ff, rsp_addr_in;
   status_type       rsp_stat_ff, rsp_stat_in;
   logic [11:0]      out_addr_ff, out_addr_in;
   status_type       out_stat_ff, out_stat_in;

   logic [31:0]      mem_ff [WORDS];
   logic [31:0]      rdata_ff;
   logic [POS_W-1:0] raddr;
   logic             we;
   logic [POS_W-1:0] waddr;
   logic [31:0]      wdata;

   logic [POS_W-1:0] sz, next_pos, rem, nx, merged;
   logic             stop;

   // Size field of the word just read, and the walk's next position.
   assign sz       = {rdata_ff[POS_W-1:3], 3'b000};
   assign stop     = (rdata_ff == LIST_TERM) || (rdata_ff[31:3] == '0);
   assign next_pos = pos_ff + sz;
   assign rem      = bsz_ff - need_ff;
   assign nx       = (free_ff ? hb_ff : best_ff) + (free_ff ? tot_ff : bsz_ff);
   assign merged   = sz + tot_ff;

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_addr = out_addr_ff;
   assign rsp_status       = out_stat_ff;

   // Sequencer: one memory access per cycle.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      free_in      = free_ff;
      found_in     = found_ff;
      bpa_in       = bpa_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      bsz_in       = bsz_ff;
      need_in      = need_ff;
      hb_in        = hb_ff;
      prev_in      = prev_ff;
      base_in      = base_ff;
      tot_in       = tot_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      out_addr_in  = out_addr_ff;
      out_stat_in  = out_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      raddr        = pos_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;
      unique case (state_ff)
         S_CLEAR: begin
            we    = 1'b1;
            waddr = {1'b0, clr_ff, 2'b00};
            if (clr_ff == IDX_W'(1)) begin
               wdata = 32'(FIRST_SIZE) | 32'd2;
            end else if (clr_ff == IDX_W'(WORDS - 2)) begin
               wdata = 32'(FIRST_SIZE);
            end else if (clr_ff == IDX_W'(WORDS - 1)) begin
               wdata = LIST_TERM;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               free_in     = req_mode;
               found_in    = 1'b0;
               pos_in      = FIRST_POS;
               bsz_in      = '1;
               need_in     = (POS_W'(req_req_bytes) + POS_W'(11)) & ~POS_W'(7);
               hb_in       = POS_W'(req_block_addr) - POS_W'(4);
               prev_in     = '0;
               rsp_addr_in = '0;
               state_in    = S_WRD;
               if (!req_mode && req_req_bytes == '0) begin
                  rsp_stat_in = ST_BAD_SIZE;
                  state_in    = S_DONE;
               end else if (req_mode && (req_block_addr == '0 ||
                                         req_block_addr[2:0] != 3'b000)) begin
                  rsp_stat_in = ST_BAD_PTR;
                  state_in    = S_DONE;
               end
            end
         end
         S_WRD: begin
            raddr    = pos_ff;
            state_in = S_WCHK;
         end
         S_WCHK: begin
            if (stop) begin
               state_in = S_DONE;
               if (free_ff) begin
                  rsp_stat_in = ST_BAD_PTR;
               end else if (found_ff) begin
                  state_in = S_ARB;
               end else begin
                  rsp_stat_in = ST_NO_FIT;
               end
            end else if (free_ff && pos_ff == hb_ff) begin
               if (!rdata_ff[0]) begin
                  rsp_stat_in = ST_DBL_FREE;
                  state_in    = S_DONE;
               end else begin
                  // Fetch the following header while the block itself is noted.
                  raddr    = next_pos;
                  tot_in   = sz;
                  bpa_in   = rdata_ff[1];
                  state_in = S_FNX;
               end
            end else begin
               if (!free_ff && !rdata_ff[0] && sz >= need_ff && sz < bsz_ff) begin
                  bsz_in   = sz;
                  best_in  = pos_ff;
                  found_in = 1'b1;
               end
               prev_in  = pos_ff;
               pos_in   = next_pos;
               state_in = S_WRD;
               if (next_pos >= END_POS) begin
                  state_in = S_DONE;
                  if (free_ff) begin
                     rsp_stat_in = ST_BAD_PTR;
                  end else if (found_ff || (!rdata_ff[0] && sz >= need_ff)) begin
                     state_in = S_ARB;
                  end else begin
                     rsp_stat_in = ST_NO_FIT;
                  end
               end
            end
         end
         // Allocate: fetch the chosen header, then split or mark the follower.
         S_ARB: begin
            raddr    = best_ff;
            state_in = S_ASPL;
         end
         S_ASPL: begin
            bpa_in = rdata_ff[1];
            if (rem >= POS_W'(8)) begin
               we       = 1'b1;
               waddr    = best_ff + need_ff;
               wdata    = 32'(rem) | 32'd2;
               state_in = S_AW2;
            end else begin
               raddr    = nx;
               state_in = S_ANX;
            end
         end
         S_AW2: begin
            we       = 1'b1;
            waddr    = best_ff + bsz_ff - POS_W'(4);
            wdata    = 32'(rem);
            state_in = S_AHDR;
         end
         S_ANX: begin
            if (rdata_ff != LIST_TERM && nx < END_POS) begin
               we    = 1'b1;
               waddr = nx;
               wdata = rdata_ff | 32'd2;
            end
            state_in = S_AHDR;
         end
         S_AHDR: begin
            we          = 1'b1;
            waddr       = best_ff;
            wdata       = 32'(need_ff) | {30'd0, bpa_ff, 1'b1};
            rsp_addr_in = 12'(best_ff + POS_W'(4));
            rsp_stat_in = ST_OK;
            state_in    = S_DONE;
         end
         // Free: look at the next block, then merge backwards or rewrite in place.
         S_FNX: begin
            if (nx < END_POS && rdata_ff != LIST_TERM) begin
               if (!rdata_ff[0]) begin
                  tot_in = tot_ff + sz;
               end else begin
                  we    = 1'b1;
                  waddr = nx;
                  wdata = rdata_ff & ~32'd2;
               end
            end
            state_in = S_FRP;
         end
         S_FRP: begin
            if (!bpa_ff && hb_ff > FIRST_POS) begin
               raddr    = prev_ff;
               state_in = S_FP;
            end else begin
               we       = 1'b1;
               waddr    = hb_ff;
               wdata    = 32'(tot_ff) | 32'd2;
               base_in  = hb_ff;
               state_in = S_FW2;
            end
         end
         S_FP: begin
            we       = 1'b1;
            waddr    = prev_ff;
            wdata    = 32'(merged) | {30'd0, rdata_ff[1], 1'b0};
            base_in  = prev_ff;
            tot_in   = merged;
            state_in = S_FW2;
         end
         S_FW2: begin
            we          = 1'b1;
            waddr       = base_ff + tot_ff - POS_W'(4);
            wdata       = 32'(tot_ff);
            rsp_stat_in = ST_OK;
            state_in    = S_DONE;
         end
         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_addr_in  = rsp_addr_ff;
               out_stat_in  = rsp_stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Heap memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr[IDX_W+1:2]] <= wdata;
      end
      rdata_ff <= mem_ff[raddr[IDX_W+1:2]];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      free_ff     <= free_in;
      found_ff    <= found_in;
      bpa_ff      <= bpa_in;
      pos_ff      <= pos_in;
      best_ff     <= best_in;
      bsz_ff      <= bsz_in;
      need_ff     <= need_in;
      hb_ff       <= hb_in;
      prev_ff     <= prev_in;
      base_ff     <= base_in;
      tot_ff      <= tot_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
      out_addr_ff <= out_addr_in;
      out_stat_ff <= out_stat_in;
   end

   // A refused request never carries an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_payload_addr == '0)
      else $error("refused request carries an address");

   // A granted allocation points at a payload aligned to 4 bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_addr != '0 |-> rsp_payload_addr[2:0] == 3'b100 ||
      rsp_payload_addr[2:0] == 3'b000)
      else $error("granted address misaligned");

   // No request is taken while the heap image is being written.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule

// ===== bench/heap_alloc_checker.sv =====
// Checker for the best-fit heap allocator: watches both channels, keeps a word-level
// model of the heap and compares every result transfer with the predicted one.
// Depends on bfha_pkg.
module heap_alloc_checker
   import bfha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_mode,
   input  logic [11:0] req_req_bytes,
   input  logic [11:0] req_block_addr,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [11:0] rsp_payload_addr,
   input  logic [2:0]  rsp_status,
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic [11:0] addr;
      status_type  status;
   } grant_type;

   logic [31:0] heap_image [WORDS];
   grant_type   expected_grants [$];

   function automatic logic [31:0] heap_read(int unsigned byte_pos);
      int unsigned idx;
      idx = byte_pos >> 2;
      return (idx < WORDS) ? heap_image[idx] : 32'd0;
   endfunction

   function automatic void heap_write(int unsigned byte_pos, logic [31:0] value);
      int unsigned idx;
      idx = byte_pos >> 2;
      if (idx < WORDS) heap_image[idx] = value;
   endfunction

   function automatic void heap_init();
      foreach (heap_image[i]) heap_image[i] = '0;
      heap_write(4, (HEAP_BYTES - 8) | 2);
      heap_write(HEAP_BYTES - 8, HEAP_BYTES - 8);
      heap_write(HEAP_BYTES - 4, LIST_TERM);
   endfunction

   // Best-fit allocation over the implicit block list.
   function automatic grant_type predict_alloc(int unsigned want);
      grant_type   g;
      int unsigned need, pos, best, best_sz, w, sz, nx, nw;
      bit          found;
      g = '{addr: '0, status: ST_OK};
      best = 0;
      best_sz = 32'hFFFF_FFFF;
      found = 0;
      if (want == 0) begin
         g.status = ST_BAD_SIZE;
         return g;
      end
      need = (want + 11) & ~32'd7;
      pos = 4;
      while (pos < HEAP_BYTES - 4) begin
         w = heap_read(pos);
         sz = w & ~32'd7;
         if (w == 1 || sz == 0) break;
         if ((w & 1) == 0 && sz >= need && sz < best_sz) begin
            best_sz = sz;
            best = pos;
            found = 1;
         end
         pos += sz;
      end
      if (!found) begin
         g.status = ST_NO_FIT;
         return g;
      end
      if (best_sz - need >= 8) begin
         heap_write(best + need, (best_sz - need) | 2);
         heap_write(best + best_sz - 4, best_sz - need);
      end else begin
         nx = best + best_sz;
         nw = heap_read(nx);
         if (nw != 1 && nx < HEAP_BYTES - 4) heap_write(nx, nw | 2);
      end
      heap_write(best, need | (heap_read(best) & 2) | 1);
      g.addr = 12'(best + 4);
      return g;
   endfunction

   // Release with pointer checks and merging on both sides.
   function automatic grant_type predict_free(int unsigned ptr);
      grant_type   g;
      int unsigned hb, pos, prev, w, s, nx, nw, pw, sz, tot;
      bit          hit;
      g = '{addr: '0, status: ST_OK};
      prev = 0;
      hit = 0;
      if (ptr == 0 || (ptr & 7) != 0 || ptr >= HEAP_BYTES) begin
         g.status = ST_BAD_PTR;
         return g;
      end
      hb = ptr - 4;
      pos = 4;
      while (pos < HEAP_BYTES - 4) begin
         pw = heap_read(pos);
         sz = pw & ~32'd7;
         if (pw == 1 || sz == 0) break;
         if (pos == hb) begin
            hit = 1;
            break;
         end
         prev = pos;
         pos += sz;
      end
      if (!hit) begin
         g.status = ST_BAD_PTR;
         return g;
      end
      w = heap_read(hb);
      if ((w & 1) == 0) begin
         g.status = ST_DBL_FREE;
         return g;
      end
      s = w & ~32'd7;
      nx = hb + s;
      nw = heap_read(nx);
      if (nx < HEAP_BYTES - 4 && nw != 1) begin
         if ((nw & 1) == 0) s += nw & ~32'd7;
         else heap_write(nx, nw & ~32'd2);
      end
      if ((w & 2) == 0 && hb > 4) begin
         pw = heap_read(prev);
         tot = (pw & ~32'd7) + s;
         heap_write(prev, tot | (pw & 2));
         heap_write(prev + tot - 4, tot);
      end else begin
         heap_write(hb, s | 2);
         heap_write(hb + s - 4, s);
      end
      return g;
   endfunction

   // Predict on each request transfer, compare on each result transfer.
   always @(posedge clock) begin
      grant_type g;
      int        errs;
      errs = 0;
      if (reset) begin
         heap_init();
         expected_grants.delete();
         error_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_mode == 1'b0) g = predict_alloc(req_req_bytes);
            else g = predict_free(req_block_addr);
            expected_grants.push_back(g);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $error("result transfer with nothing expected: payload_addr %0d status %0d",
                      rsp_payload_addr, rsp_status);
               errs++;
            end else begin
               g = expected_grants.pop_front();
               if (rsp_payload_addr !== g.addr) begin
                  $error("payload_addr expected %0d actual %0d", g.addr, rsp_payload_addr);
                  errs++;
               end
               if (rsp_status !== g.status) begin
                  $error("status expected %0d actual %0d", g.status, rsp_status);
                  errs++;
               end
            end
         end
         if (errs != 0) error_count <= error_count + errs;
      end
      pending_count = expected_grants.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the heap allocator testbench: clock, reset, request stimulus and verdict.
// Depends on bfha_pkg, best_fit_heap_allocator_top and heap_alloc_checker.
module tb_top;
   import bfha_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [11:0] req_req_bytes;
   logic [11:0] req_block_addr;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_payload_addr;
   logic [2:0]  rsp_status;
   int          error_count;
   int          pending_count;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int unsigned cycle_count;
   logic [11:0] live_blocks [$];

   localparam int unsigned CYCLE_LIMIT = 20_000_000;

   best_fit_heap_allocator_top dut (.*);

   heap_alloc_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver stalls at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Keep track of granted payloads so that frees mostly hit live blocks.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_status == ST_OK && rsp_payload_addr != 0)
         live_blocks.push_back(rsp_payload_addr);
   end

   // One request transfer, with an optional idle gap ahead of it.
   // Ready is sampled at the falling edge ahead of each rising edge, where it is settled.
   task automatic send_request(logic mode, logic [11:0] bytes, logic [11:0] addr);
      logic taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_req_bytes  <= bytes;
      req_block_addr <= addr;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Random request: mostly sensible allocs and frees of live blocks, some noise.
   task automatic send_random();
      int          pick;
      int          idx;
      logic [11:0] addr;
      pick = $urandom_range(99);
      if (pick < 45) begin
         if ($urandom_range(9) == 0) send_request(1'b0, 12'($urandom), 12'($urandom));
         else send_request(1'b0, 12'($urandom_range(200)), 12'($urandom));
      end else if (pick < 85 && live_blocks.size() > 0) begin
         idx = $urandom_range(live_blocks.size() - 1);
         addr = live_blocks[idx];
         live_blocks.delete(idx);
         send_request(1'b1, 12'($urandom), addr);
      end else if (pick < 92) begin
         send_request(1'b1, 12'($urandom), 12'($urandom_range(511) * 8));
      end else begin
         send_request(1'b1, 12'($urandom), 12'($urandom));
      end
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_req_bytes = '0;
      req_block_addr = '0;
      rsp_ready = 1'b0;
      cycle_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero size, too large, whole heap, bad pointers, double free, merges.
      send_request(1'b0, 12'd0, 12'hFFF);
      send_request(1'b0, 12'hFFF, 12'd0);
      send_request(1'b0, 12'd4084, 12'd0);
      send_request(1'b0, 12'd4085, 12'd0);
      send_request(1'b1, 12'hFFF, 12'd8);
      send_request(1'b1, 12'd0, 12'd0);
      send_request(1'b1, 12'd0, 12'd12);
      send_request(1'b1, 12'd0, 12'hFF8);
      send_request(1'b1, 12'd0, 12'd8);
      send_request(1'b0, 12'd1, 12'd0);
      send_request(1'b0, 12'd4, 12'd0);
      send_request(1'b0, 12'd5, 12'd0);
      send_request(1'b0, 12'd100, 12'd0);
      send_request(1'b1, 12'd0, 12'd16);
      send_request(1'b1, 12'd0, 12'd16);
      send_request(1'b1, 12'd0, 12'd24);
      send_request(1'b1, 12'd0, 12'd8);
      send_request(1'b0, 12'd3000, 12'd0);
      send_request(1'b0, 12'd1100, 12'd0);
      send_request(1'b1, 12'd0, 12'd40);
      send_request(1'b1, 12'd0, 12'd8);

      // Random phases with different idle and stall rates.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
            default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
         endcase
         n = 0;
         while (n < 410) begin
            send_random();
            n++;
         end
      end
      req_valid <= 1'b0;
      receiver_stall_pct = 0;

      // Let the checker record the last request before waiting for its result.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
